// ===== rtl/core/rlei_pkg.sv =====
// Shared types and constants for the run/lumi/event index lookup block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rlei_pkg;

  // Field widths of the input and result items.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned RUN_W   = 32;
  localparam int unsigned LUMI_W  = 32;
  localparam int unsigned EVENT_W = 32;
  localparam int unsigned ENTRY_W = 40;
  localparam int unsigned POS_W   = 11;

  // Operation carried by one input item.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR      = 2'd0,
    KIND_APPEND     = 2'd1,
    KIND_FIND       = 2'd2,
    KIND_FIND_ENTRY = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the query on an input transfer
    logic clear;       // empty the table
    logic append;      // write the query at the next free position
    logic scan_start;  // rewind the scan pointers
    logic scan_run;    // advance the scan by one entry
    logic res_load;    // capture the result of the current operation
    logic out_load;    // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;       // operation of the captured query
    logic  full;       // entry count has reached the table depth
    logic  empty;      // entry count is zero
    logic  hit;        // entry under comparison matches the query
    logic  scan_end;   // the scan has passed the last stored entry
    logic  out_free;   // output register can take a new result
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rlei_if.sv =====
// Valid/ready channel interfaces for the query and result transfers.
// Depends on rlei_pkg for the field widths.
`default_nettype none

interface rlei_in_if import rlei_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [RUN_W-1:0]   run_number;
  logic [LUMI_W-1:0]  lumi_number;
  logic [EVENT_W-1:0] event_number;
  logic [ENTRY_W-1:0] entry_number;

  modport source (
    output valid, kind, run_number, lumi_number, event_number, entry_number,
    input  ready
  );
  modport sink (
    input  valid, kind, run_number, lumi_number, event_number, entry_number,
    output ready
  );
endinterface

interface rlei_out_if import rlei_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             full_res;

  modport source (
    output valid, found, position, full_res,
    input  ready
  );
  modport sink (
    input  valid, found, position, full_res,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/rlei_ctrl.sv =====
// Controller state machine of the index lookup block.
// Depends on rlei_pkg; drives the datapath rlei_dpath through command structs.
`default_nettype none

module rlei_ctrl import rlei_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (stat_i.kind) inside
          KIND_CLEAR: begin
            cmd_o.clear    = 1'b1;
            cmd_o.res_load = 1'b1;
            state_d        = ST_FIN;
          end
          KIND_APPEND: begin
            cmd_o.append   = !stat_i.full;
            cmd_o.res_load = 1'b1;
            state_d        = ST_FIN;
          end
          KIND_FIND, KIND_FIND_ENTRY: begin
            // An empty table misses at once.
            if (stat_i.empty) begin
              cmd_o.res_load = 1'b1;
              state_d        = ST_FIN;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.hit || stat_i.scan_end) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hand the result over once the output register is free.
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rlei_dpath.sv =====
// Datapath of the index lookup block: entry memory, count, scan and result.
// Depends on rlei_pkg; commanded by the controller rlei_ctrl.
`default_nettype none

module rlei_dpath import rlei_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_stat_t         stat_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [RUN_W-1:0]   run_number_i,
  input  logic [LUMI_W-1:0]  lumi_number_i,
  input  logic [EVENT_W-1:0] event_number_i,
  input  logic [ENTRY_W-1:0] entry_number_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               found_o,
  output logic [POS_W-1:0]   position_o,
  output logic               full_res_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ROW_W = RUN_W + LUMI_W + EVENT_W + ENTRY_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // Captured query.
  kind_e              q_kind_q;
  logic [RUN_W-1:0]   q_run_q;
  logic [LUMI_W-1:0]  q_lumi_q;
  logic [EVENT_W-1:0] q_event_q;
  logic [ENTRY_W-1:0] q_entry_q;
  logic               any_lumi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      q_kind_q   <= kind_e'(kind_i);
      q_run_q    <= run_number_i;
      q_lumi_q   <= lumi_number_i;
      q_event_q  <= event_number_i;
      q_entry_q  <= entry_number_i;
      any_lumi_q <= (lumi_number_i == '0) && (event_number_i != '0);
    end
  end

  // Entry count and scan pointers.
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] issue_q;
  logic [CNT_W-1:0] cmp_ptr_q;
  logic             cmp_vld_q;
  logic             cmp_end_q;
  logic             issue_live;

  assign issue_live = issue_q < count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      issue_q   <= '0;
      cmp_ptr_q <= '0;
      cmp_vld_q <= 1'b0;
      cmp_end_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.append) begin
        count_q <= count_q + 1'b1;
      end
      // The compare stage works on the read address of the previous cycle.
      cmp_ptr_q <= issue_q;
      cmp_vld_q <= cmd_i.scan_run && issue_live;
      cmp_end_q <= cmd_i.scan_run && !issue_live;
      if (cmd_i.scan_start) begin
        issue_q <= '0;
      end else if (cmd_i.scan_run && issue_live) begin
        issue_q <= issue_q + 1'b1;
      end
    end
  end

  // Entry memory: one row holds run, lumi, event and entry number.
  logic [ROW_W-1:0] mem [TABLE_DEPTH];
  logic [ROW_W-1:0] rd_row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[count_q[IDX_W-1:0]] <= {q_run_q, q_lumi_q, q_event_q, q_entry_q};
    end
    rd_row_q <= mem[issue_q[IDX_W-1:0]];
  end

  // Compare the row read last cycle against the query.
  logic [RUN_W-1:0]   rd_run;
  logic [LUMI_W-1:0]  rd_lumi;
  logic [EVENT_W-1:0] rd_event;
  logic [ENTRY_W-1:0] rd_entry;
  logic               hit;

  assign {rd_run, rd_lumi, rd_event, rd_entry} = rd_row_q;
  assign hit = cmp_vld_q && (rd_run == q_run_q) && (rd_event == q_event_q)
            && (any_lumi_q || (rd_lumi == q_lumi_q))
            && ((q_kind_q != KIND_FIND_ENTRY) || (rd_entry == q_entry_q));

  // Positions are reported masked to the result field width.
  logic [CNT_W+POS_W-1:0] cnt_ext;
  logic [CNT_W+POS_W-1:0] ptr_ext;
  logic                   full;

  assign cnt_ext = {{POS_W{1'b0}}, count_q};
  assign ptr_ext = {{POS_W{1'b0}}, cmp_ptr_q};
  assign full    = count_q >= DEPTH_C;

  // Result of the current operation.
  logic             res_found_d, res_full_d;
  logic [POS_W-1:0] res_pos_d;
  logic             res_found_q, res_full_q;
  logic [POS_W-1:0] res_pos_q;

  always_comb begin
    res_found_d = 1'b0;
    res_full_d  = 1'b0;
    res_pos_d   = cnt_ext[POS_W-1:0];
    unique case (q_kind_q) inside
      KIND_CLEAR: begin
        res_pos_d = '0;
      end
      KIND_APPEND: begin
        res_found_d = !full;
        res_full_d  = full;
      end
      KIND_FIND, KIND_FIND_ENTRY: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_pos_d   = ptr_ext[POS_W-1:0];
        end
      end
      default: begin
        res_pos_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_found_q <= res_found_d;
      res_full_q  <= res_full_d;
      res_pos_q   <= res_pos_d;
    end
  end

  // Output register.
  logic             out_valid_q;
  logic             out_found_q, out_full_q;
  logic [POS_W-1:0] out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_q <= res_found_q;
      out_full_q  <= res_full_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign position_o  = out_pos_q;
  assign full_res_o  = out_full_q;

  // Status to the controller.
  assign stat_o.kind     = q_kind_q;
  assign stat_o.full     = full;
  assign stat_o.empty    = count_q == '0;
  assign stat_o.hit      = hit;
  assign stat_o.scan_end = cmp_end_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/core/run_lumi_event_index_lookup.sv =====
// Run/lumi/event index table with first-match lookup, top level.
// Depends on rlei_pkg, rlei_if, rlei_ctrl and rlei_dpath.
//
// Usage: queries arrive on the in_i channel, one result per query leaves on
// out_o. Kind clear empties the table, kind append writes the next free
// position (refused with full_res when the table holds TABLE_DEPTH entries),
// and the two find kinds return the lowest matching position, or the entry
// count on a miss. Only one query is in work at a time.
// Flow: clear, append and a find on an empty table pass from the idle state
// through the execute and finish states back to idle, and the result is
// registered before it is offered. A find reads the entry memory one row per
// cycle through a single read port, so its run time grows with the position
// of the hit, or with the number of stored entries on a miss.
// The result is held in an output register, so a new query is taken while
// an earlier result still waits on a stalled receiver; a further result
// then waits in the block until the output register is free.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none

module run_lumi_event_index_lookup import rlei_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlei_in_if.sink     in_i,
  rlei_out_if.source  out_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Controller.
  rlei_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  rlei_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (in_i.kind),
    .run_number_i   (in_i.run_number),
    .lumi_number_i  (in_i.lumi_number),
    .event_number_i (in_i.event_number),
    .entry_number_i (in_i.entry_number),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .found_o        (out_o.found),
    .position_o     (out_o.position),
    .full_res_o     (out_o.full_res)
  );

`ifndef SYNTHESIS
  // Only one query is in work: an input transfer closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a query is in work");

  // A refused append is never reported as a success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.found && out_o.full_res))
    else $error("result flags both found and full");

  // A refused append reports the full entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.full_res) |-> (out_o.position == POS_W'(TABLE_DEPTH)))
    else $error("refused append reports a wrong position");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_run_lumi_event_index_lookup.sv =====
// Self-checking testbench for the run/lumi/event index lookup block.
// Depends on rlei_pkg, the rlei_in_if and rlei_out_if interfaces, and the RTL top.
// Directed table first, then two phases of random queries, checked by a predictor.

module tb_run_lumi_event_index_lookup import rlei_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned N_DIRECTED  = 24;
  localparam int unsigned N_RANDOM    = 278;  // per random phase, two phases

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    kind_e              kind;
    logic [RUN_W-1:0]   run;
    logic [LUMI_W-1:0]  lumi;
    logic [EVENT_W-1:0] evt;
    logic [ENTRY_W-1:0] entry;
  } query_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             full_res;
  } answer_t;

  typedef struct packed {
    query_t  q;
    logic    known;  // answer below is typed in rather than predicted
    answer_t ans;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  rlei_in_if  in_if ();
  rlei_out_if out_if ();

  run_lumi_event_index_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the index table.
  logic [RUN_W-1:0]   tab_run   [TABLE_DEPTH];
  logic [LUMI_W-1:0]  tab_lumi  [TABLE_DEPTH];
  logic [EVENT_W-1:0] tab_evt   [TABLE_DEPTH];
  logic [ENTRY_W-1:0] tab_entry [TABLE_DEPTH];
  int unsigned        tab_count;

  answer_t     pending_answers [$];
  int unsigned mismatches;
  int unsigned n_checked;
  int unsigned n_clear, n_append, n_refused, n_find, n_hit, peak_count;
  bit          burst_mode;

  // Directed queries: empty table, extremes, wildcard lumi, duplicate keys, clear.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{KIND_FIND,       32'd0, 32'd0, 32'd0, 40'd0},   1'b1, '{1'b0, 11'd0, 1'b0}},
    '{'{KIND_FIND_ENTRY, 32'd0, 32'd0, 32'd0, MAX40},   1'b1, '{1'b0, 11'd0, 1'b0}},
    '{'{KIND_CLEAR,      MAX32, MAX32, MAX32, MAX40},   1'b1, '{1'b0, 11'd0, 1'b0}},
    '{'{KIND_APPEND,     MAX32, MAX32, MAX32, MAX40},   1'b1, '{1'b1, 11'd0, 1'b0}},
    '{'{KIND_APPEND,     32'd0, 32'd0, 32'd0, 40'd0},   1'b1, '{1'b1, 11'd1, 1'b0}},
    '{'{KIND_APPEND,     32'd5, 32'd0, 32'd0, 40'd7},   1'b1, '{1'b1, 11'd2, 1'b0}},
    '{'{KIND_APPEND,     32'd5, 32'd3, 32'd0, 40'd8},   1'b1, '{1'b1, 11'd3, 1'b0}},
    '{'{KIND_APPEND,     32'd5, 32'd3, 32'd9, 40'd100}, 1'b1, '{1'b1, 11'd4, 1'b0}},
    '{'{KIND_APPEND,     32'd5, 32'd4, 32'd9, 40'd200}, 1'b1, '{1'b1, 11'd5, 1'b0}},
    '{'{KIND_APPEND,     32'd5, 32'd3, 32'd9, 40'd300}, 1'b1, '{1'b1, 11'd6, 1'b0}},
    '{'{KIND_FIND,       MAX32, MAX32, MAX32, 40'd0},   1'b0, '0},
    '{'{KIND_FIND,       32'd0, 32'd0, 32'd0, MAX40},   1'b0, '0},
    '{'{KIND_FIND,       32'd5, 32'd0, 32'd0, 40'd0},   1'b0, '0},
    '{'{KIND_FIND,       32'd5, 32'd3, 32'd0, 40'd0},   1'b0, '0},
    '{'{KIND_FIND,       32'd5, 32'd0, 32'd9, 40'd0},   1'b0, '0},
    '{'{KIND_FIND,       32'd5, 32'd4, 32'd9, 40'd0},   1'b0, '0},
    '{'{KIND_FIND_ENTRY, 32'd5, 32'd3, 32'd9, 40'd300}, 1'b0, '0},
    '{'{KIND_FIND_ENTRY, 32'd5, 32'd0, 32'd9, 40'd200}, 1'b0, '0},
    '{'{KIND_FIND_ENTRY, 32'd5, 32'd3, 32'd9, 40'd200}, 1'b0, '0},
    '{'{KIND_FIND,       32'd5, 32'd7, 32'd9, 40'd0},   1'b0, '0},
    '{'{KIND_FIND_ENTRY, MAX32, MAX32, MAX32, MAX40},   1'b0, '0},
    '{'{KIND_CLEAR,      32'd0, 32'd0, 32'd0, 40'd0},   1'b1, '{1'b0, 11'd0, 1'b0}},
    '{'{KIND_FIND,       32'd0, 32'd0, 32'd0, 40'd0},   1'b1, '{1'b0, 11'd0, 1'b0}},
    '{'{KIND_APPEND,     32'd1, 32'd1, 32'd1, 40'd0},   1'b1, '{1'b1, 11'd0, 1'b0}}
  };

  // Clock and a single reset pulse at the start.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Answer of the index table to one query; updates the shadow table.
  function automatic answer_t index_answer(query_t q);
    answer_t     a;
    logic        any_lumi;
    int unsigned i;
    a = '0;
    case (q.kind)
      KIND_CLEAR: tab_count = 0;
      KIND_APPEND: begin
        a.position = POS_W'(tab_count);
        if (tab_count >= TABLE_DEPTH) begin
          a.full_res = 1'b1;
        end else begin
          tab_run[tab_count]   = q.run;
          tab_lumi[tab_count]  = q.lumi;
          tab_evt[tab_count]   = q.evt;
          tab_entry[tab_count] = q.entry;
          a.found = 1'b1;
          tab_count++;
        end
      end
      default: begin
        // Lumi 0 is a wildcard only when the event number is nonzero.
        any_lumi = (q.lumi == '0) && (q.evt != '0);
        a.position = POS_W'(tab_count);
        for (i = 0; i < tab_count && !a.found; i++) begin
          if (tab_run[i] == q.run && tab_evt[i] == q.evt &&
              (any_lumi || tab_lumi[i] == q.lumi) &&
              (q.kind != KIND_FIND_ENTRY || tab_entry[i] == q.entry)) begin
            a.found    = 1'b1;
            a.position = POS_W'(i);
          end
        end
      end
    endcase
    return a;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Operation mix; large tables are cleared so that scans stay short.
  function automatic kind_e random_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tab_count >= 96 || r < 4) return KIND_CLEAR;
    if (r < 45) return KIND_APPEND;
    if (r < 78) return KIND_FIND;
    return KIND_FIND_ENTRY;
  endfunction

  // Random query content, biased towards keys already in the table.
  function automatic query_t random_query(kind_e k);
    query_t      q;
    int unsigned j, r, b;
    q.kind  = k;
    q.run   = $urandom();
    q.lumi  = $urandom();
    q.evt   = $urandom();
    q.entry = {8'($urandom_range(0, 255)), 32'($urandom())};
    r = $urandom_range(0, 99);
    if (k == KIND_APPEND) begin
      if (tab_count > 0 && r < 35) begin
        // Repeated key with a fresh entry number, so first-match order matters.
        j = $urandom_range(0, tab_count - 1);
        q.run  = tab_run[j];
        q.lumi = tab_lumi[j];
        q.evt  = tab_evt[j];
      end else if (r < 50) begin
        q.evt = '0;
      end else if (r < 60) begin
        q.evt  = '0;
        q.lumi = '0;
      end else if (r < 75) begin
        q.run  = $urandom_range(0, 3);
        q.lumi = $urandom_range(0, 3);
        q.evt  = $urandom_range(0, 3);
      end
    end else if (k != KIND_CLEAR && tab_count > 0 && r < 70) begin
      j = $urandom_range(0, tab_count - 1);
      q.run   = tab_run[j];
      q.lumi  = tab_lumi[j];
      q.evt   = tab_evt[j];
      q.entry = tab_entry[j];
      if ($urandom_range(0, 3) == 0 && q.evt != '0) q.lumi = '0;
      // Occasionally spoil one bit so that near misses are tried.
      if ($urandom_range(0, 4) == 0) begin
        b = $urandom_range(0, 31);
        case ($urandom_range(0, 3))
          0:       q.run[b]  = ~q.run[b];
          1:       q.lumi[b] = ~q.lumi[b];
          2:       q.evt[b]  = ~q.evt[b];
          default: q.entry[b + 8] = ~q.entry[b + 8];
        endcase
      end
    end
    return q;
  endfunction

  // Drive one query and wait for its transfer; valid stays high across back-to-back queries.
  task automatic send_query(query_t q, logic known, answer_t typed_ans);
    int unsigned gap;
    answer_t     a;
    gap = burst_mode ? 0 : idle_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= q.kind;
    in_if.run_number   <= q.run;
    in_if.lumi_number  <= q.lumi;
    in_if.event_number <= q.evt;
    in_if.entry_number <= q.entry;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    a = index_answer(q);
    pending_answers = {pending_answers, (known ? typed_ans : a)};
    case (q.kind)
      KIND_CLEAR:  n_clear++;
      KIND_APPEND: begin
        n_append++;
        if (a.full_res) n_refused++;
      end
      default: begin
        n_find++;
        if (a.found) n_hit++;
      end
    endcase
    if (tab_count > peak_count) peak_count = tab_count;
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls between runs of ready.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (idle_gap() != 0) begin
        out_if.ready <= 1'b0;
        repeat (idle_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest outstanding answer.
  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, found %0b position %0d full_res %0b",
                 $time, out_if.found, out_if.position, out_if.full_res);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        check_field("found", want.found, out_if.found);
        check_field("position", want.position, out_if.position);
        check_field("full_res", want.full_res, out_if.full_res);
        n_checked++;
      end
    end
  end

  // Stimulus: directed table, then two random phases.
  initial begin : stimulus
    int unsigned k;
    answer_t     none;
    none = '0;
    tab_count  = 0;
    burst_mode = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_CLEAR;
    in_if.run_number   <= '0;
    in_if.lumi_number  <= '0;
    in_if.event_number <= '0;
    in_if.entry_number <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    for (k = 0; k < N_DIRECTED; k++) begin
      send_query(directed_rows[k].q, directed_rows[k].known, directed_rows[k].ans);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_query(random_query(random_kind()), 1'b0, none);
    end
    burst_mode = 1'b0;

    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_query(random_query(random_kind()), 1'b0, none);
    end
    in_if.valid <= 1'b0;

    // Drain, then allow time for any stray result to show up.
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 16) @(posedge clk_i);

    $display("Ran %0d clears, %0d appends (%0d refused on a full table), %0d finds (%0d hits).",
             n_clear, n_append, n_refused, n_find, n_hit);
    $display("Largest table held %0d entries; %0d results compared, %0d mismatches.",
             peak_count, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
